>>> rtl/core/ctl_pkg.sv
`timescale 1ns / 1ps
package ctl_pkg;

  localparam int unsigned LineBits = 16;
  localparam int unsigned NumRes   = 4;
  localparam int unsigned CntBits  = 3;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QIdxBits = 2;

  localparam logic [LineBits-1:0] LineTop = {LineBits{1'b1}};

  typedef enum logic [11:0] {
    ModeIdle      = 12'h001,
    ModePendB     = 12'h002,
    ModePendSlash = 12'h004,
    ModeString    = 12'h008,
    ModeBinary    = 12'h010,
    ModeNumber    = 12'h020,
    ModeNumExp    = 12'h040,
    ModeIdent     = 12'h080,
    ModeHash      = 12'h100,
    ModeSlashC    = 12'h200,
    ModeBlock     = 12'h400,
    ModeBlockStar = 12'h800
  } mode_e;

  typedef enum logic [3:0] {
    TokEof    = 4'd0,
    TokEqual  = 4'd1,
    TokLbrace = 4'd2,
    TokRbrace = 4'd3,
    TokLbrack = 4'd4,
    TokRbrack = 4'd5,
    TokString = 4'd6,
    TokBinary = 4'd7,
    TokInt    = 4'd8,
    TokDouble = 4'd9,
    TokBool   = 4'd10,
    TokIdent  = 4'd11,
    TokComment = 4'd12,
    TokUnknown = 4'd13
  } tok_e;

  localparam logic [1:0] CmtNone  = 2'd0;
  localparam logic [1:0] CmtHash  = 2'd1;
  localparam logic [1:0] CmtSlash = 2'd2;
  localparam logic [1:0] CmtBlock = 2'd3;

  localparam logic [2:0] ErrNone   = 3'd0;
  localparam logic [2:0] ErrEscape = 3'd1;
  localparam logic [2:0] ErrString = 3'd2;
  localparam logic [2:0] ErrBinary = 3'd3;
  localparam logic [2:0] ErrBlock  = 3'd4;

  localparam logic       RecContent = 1'b0;
  localparam logic       RecFinish  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  tok;
    logic [1:0]  cmt;
    logic [7:0]  data;
    logic [15:0] line;
    logic [2:0]  err;
  } rec_t;

  // one input byte's worth of results
  typedef struct packed {
    logic [CntBits-1:0] cnt;
    rec_t [NumRes-1:0]  recs;
  } bundle_t;

endpackage

>>> rtl/core/ctl_front.sv
`timescale 1ns / 1ps
module ctl_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [15:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               byte_i,
  input  logic                     eos_i,
  output logic                     push_o,
  input  logic                     full_i,
  output ctl_pkg::bundle_t         bundle_o
);
  import ctl_pkg::*;

  logic [15:0]          start_q;
  mode_e                mode_q, mode_d;
  logic                 esc_q, esc_d, dbl_q, dbl_d, txt_q, txt_d;
  logic [3:0]           kw_q, kw_d;
  logic [LineBits-1:0]  line_q, line_d, cstart_q, cstart_d;
  bundle_t              b;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && !full_i;
  assign bundle_o    = b;

  function automatic logic is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alp(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic [3:0] kw_step(logic [3:0] k, logic [7:0] c);
    logic [7:0] w;
    w = 8'd0;
    case (k)
      4'd1: w = "r";
      4'd2: w = "u";
      4'd3: w = "e";
      4'd5: w = "a";
      4'd6: w = "l";
      4'd7: w = "s";
      4'd8: w = "e";
      default: w = 8'd0;
    endcase
    return (w != 8'd0 && w == c) ? k + 4'd1 : 4'd0;
  endfunction

  logic [LineBits-1:0] start_sat;
  always_comb begin
    if (LineBits >= 16) start_sat = LineBits'(start_q);
    else start_sat = (start_q < 16'(LineTop)) ? LineBits'(start_q) : LineTop;
  end

  always_comb begin
    logic [7:0] c;
    logic       redo;
    c = byte_i;
    mode_d = mode_q; esc_d = esc_q; dbl_d = dbl_q; txt_d = txt_q;
    kw_d = kw_q; line_d = line_q; cstart_d = cstart_q;
    b = '0;
    redo = 1'b0;

    if (eos_i) begin
      unique case (mode_q) inside
        ModePendB: begin
          b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, "b", 16'd0, ErrNone};
          b.cnt = b.cnt + 1'b1;
          b.recs[b.cnt[1:0]] = '{RecFinish, TokIdent, CmtNone, 8'd0, line_q[15:0], ErrNone};
          b.cnt = b.cnt + 1'b1;
        end
        ModePendSlash: begin
          b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, "/", 16'd0, ErrNone};
          b.cnt = b.cnt + 1'b1;
          b.recs[b.cnt[1:0]] = '{RecFinish, TokUnknown, CmtNone, 8'd0, line_q[15:0], ErrNone};
          b.cnt = b.cnt + 1'b1;
        end
        ModeString: begin
          b.recs[b.cnt[1:0]] = '{RecFinish, TokUnknown, CmtNone, 8'd0, line_q[15:0], ErrString};
          b.cnt = b.cnt + 1'b1;
        end
        ModeBinary: begin
          b.recs[b.cnt[1:0]] = '{RecFinish, TokUnknown, CmtNone, 8'd0, line_q[15:0], ErrBinary};
          b.cnt = b.cnt + 1'b1;
        end
        ModeNumber, ModeNumExp: begin
          b.recs[b.cnt[1:0]] = '{RecFinish, dbl_q ? TokDouble : TokInt, CmtNone, 8'd0,
                                 line_q[15:0], ErrNone};
          b.cnt = b.cnt + 1'b1;
        end
        ModeIdent: begin
          b.recs[b.cnt[1:0]] = '{RecFinish,
                                 (kw_q == 4'd4 || kw_q == 4'd9) ? TokBool : TokIdent,
                                 CmtNone, 8'd0, line_q[15:0], ErrNone};
          b.cnt = b.cnt + 1'b1;
        end
        ModeHash: begin
          b.recs[b.cnt[1:0]] = '{RecFinish, TokComment, CmtHash, 8'd0, line_q[15:0], ErrNone};
          b.cnt = b.cnt + 1'b1;
        end
        ModeSlashC: begin
          b.recs[b.cnt[1:0]] = '{RecFinish, TokComment, CmtSlash, 8'd0, line_q[15:0], ErrNone};
          b.cnt = b.cnt + 1'b1;
        end
        ModeBlock: begin
          b.recs[b.cnt[1:0]] = '{RecFinish, TokUnknown, CmtNone, 8'd0, line_q[15:0], ErrBlock};
          b.cnt = b.cnt + 1'b1;
        end
        ModeBlockStar: begin
          b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, "*", 16'd0, ErrNone};
          b.cnt = b.cnt + 1'b1;
          b.recs[b.cnt[1:0]] = '{RecFinish, TokUnknown, CmtNone, 8'd0, line_q[15:0], ErrBlock};
          b.cnt = b.cnt + 1'b1;
        end
        default: ;
      endcase
      b.recs[b.cnt[1:0]] = '{RecFinish, TokEof, CmtNone, 8'd0, line_q[15:0], ErrNone};
      b.cnt = b.cnt + 1'b1;
      mode_d = ModeIdle; esc_d = 1'b0; dbl_d = 1'b0; txt_d = 1'b0; kw_d = '0;
      cstart_d = '0; line_d = start_sat;
    end else begin
      // first pass: mode-specific handling; redo falls through to idle handling
      unique case (mode_q) inside
        ModeIdle: redo = 1'b1;
        ModePendB: begin
          if (c == "\"") mode_d = ModeBinary;
          else begin
            b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, "b", 16'd0, ErrNone};
            b.cnt = b.cnt + 1'b1;
            if (is_alp(c) || is_dig(c) || c == "_" || c == ".") begin
              b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
              b.cnt = b.cnt + 1'b1;
              kw_d = 4'd0; mode_d = ModeIdent;
            end else begin
              b.recs[b.cnt[1:0]] = '{RecFinish, TokIdent, CmtNone, 8'd0, line_q[15:0], ErrNone};
              b.cnt = b.cnt + 1'b1;
              kw_d = 4'd0;
              redo = 1'b1;
            end
          end
        end
        ModePendSlash: begin
          if (c == "/") mode_d = ModeSlashC;
          else if (c == "*") begin
            mode_d = ModeBlock; cstart_d = line_q;
          end else begin
            b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, "/", 16'd0, ErrNone};
            b.cnt = b.cnt + 1'b1;
            b.recs[b.cnt[1:0]] = '{RecFinish, TokUnknown, CmtNone, 8'd0, line_q[15:0], ErrNone};
            b.cnt = b.cnt + 1'b1;
            redo = 1'b1;
          end
        end
        ModeString: begin
          if (esc_q) begin
            esc_d = 1'b0;
            case (c) inside
              "\"", "\\": begin
                b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
                b.cnt = b.cnt + 1'b1;
              end
              "n": begin
                b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, 8'h0a, 16'd0, ErrNone};
                b.cnt = b.cnt + 1'b1;
              end
              "r": begin
                b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, 8'h0d, 16'd0, ErrNone};
                b.cnt = b.cnt + 1'b1;
              end
              "t": begin
                b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, 8'h09, 16'd0, ErrNone};
                b.cnt = b.cnt + 1'b1;
              end
              default: begin
                b.recs[b.cnt[1:0]] = '{RecFinish, TokUnknown, CmtNone, 8'd0, line_q[15:0],
                                       ErrEscape};
                b.cnt = b.cnt + 1'b1;
                mode_d = ModeIdle;
              end
            endcase
          end else if (c == "\\") esc_d = 1'b1;
          else if (c == "\"") begin
            b.recs[b.cnt[1:0]] = '{RecFinish, TokString, CmtNone, 8'd0, line_q[15:0], ErrNone};
            b.cnt = b.cnt + 1'b1;
            mode_d = ModeIdle;
          end else begin
            if (c == 8'h0a && line_q != LineTop) line_d = line_q + 1'b1;
            b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
            b.cnt = b.cnt + 1'b1;
          end
        end
        ModeBinary: begin
          if (c == "\"") begin
            b.recs[b.cnt[1:0]] = '{RecFinish, TokBinary, CmtNone, 8'd0, line_q[15:0], ErrNone};
            b.cnt = b.cnt + 1'b1;
            mode_d = ModeIdle;
          end else begin
            if (c == 8'h0a && line_q != LineTop) line_d = line_q + 1'b1;
            b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
            b.cnt = b.cnt + 1'b1;
          end
        end
        ModeNumber, ModeNumExp: begin
          mode_d = ModeNumber;
          if (mode_q == ModeNumExp && (c == "+" || c == "-")) begin
            b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
            b.cnt = b.cnt + 1'b1;
          end else if (is_dig(c)) begin
            b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
            b.cnt = b.cnt + 1'b1;
          end else if (c == "." && !dbl_q) begin
            dbl_d = 1'b1;
            b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
            b.cnt = b.cnt + 1'b1;
          end else if ((c == "e" || c == "E") && txt_q) begin
            dbl_d = 1'b1; mode_d = ModeNumExp;
            b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
            b.cnt = b.cnt + 1'b1;
          end else begin
            b.recs[b.cnt[1:0]] = '{RecFinish, dbl_q ? TokDouble : TokInt, CmtNone, 8'd0,
                                   line_q[15:0], ErrNone};
            b.cnt = b.cnt + 1'b1;
            redo = 1'b1;
          end
        end
        ModeIdent: begin
          if (is_alp(c) || is_dig(c) || c == "_" || c == ".") begin
            b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
            b.cnt = b.cnt + 1'b1;
            kw_d = kw_step(kw_q, c);
          end else begin
            b.recs[b.cnt[1:0]] = '{RecFinish,
                                   (kw_q == 4'd4 || kw_q == 4'd9) ? TokBool : TokIdent,
                                   CmtNone, 8'd0, line_q[15:0], ErrNone};
            b.cnt = b.cnt + 1'b1;
            redo = 1'b1;
          end
        end
        ModeHash, ModeSlashC: begin
          if (c == 8'h0a) begin
            line_d = (line_q != LineTop) ? line_q + 1'b1 : line_q;
            b.recs[b.cnt[1:0]] = '{RecFinish, TokComment,
                                   (mode_q == ModeHash) ? CmtHash : CmtSlash,
                                   8'd0, line_d[15:0], ErrNone};
            b.cnt = b.cnt + 1'b1;
            mode_d = ModeIdle;
          end else begin
            b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
            b.cnt = b.cnt + 1'b1;
          end
        end
        ModeBlock, ModeBlockStar: begin
          if (mode_q == ModeBlockStar && c == "/") begin
            b.recs[b.cnt[1:0]] = '{RecFinish, TokComment, CmtBlock, 8'd0, cstart_q[15:0],
                                   ErrNone};
            b.cnt = b.cnt + 1'b1;
            mode_d = ModeIdle;
          end else begin
            if (mode_q == ModeBlockStar) begin
              b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, "*", 16'd0, ErrNone};
              b.cnt = b.cnt + 1'b1;
            end
            mode_d = ModeBlock;
            if (c == "*") mode_d = ModeBlockStar;
            else begin
              if (c == 8'h0a && line_q != LineTop) line_d = line_q + 1'b1;
              b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
              b.cnt = b.cnt + 1'b1;
            end
          end
        end
        default: redo = 1'b1;
      endcase

      if (redo) begin
        mode_d = ModeIdle;
        case (c) inside
          8'h0a: if (line_q != LineTop) line_d = line_q + 1'b1;
          8'h20, 8'h09, 8'h0d: ;
          "=", "{", "}", "[", "]": begin
            b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
            b.cnt = b.cnt + 1'b1;
            b.recs[b.cnt[1:0]] = '{RecFinish,
                                   (c == "=") ? TokEqual : (c == "{") ? TokLbrace :
                                   (c == "}") ? TokRbrace : (c == "[") ? TokLbrack : TokRbrack,
                                   CmtNone, 8'd0, line_q[15:0], ErrNone};
            b.cnt = b.cnt + 1'b1;
          end
          "b": mode_d = ModePendB;
          "\"": begin
            mode_d = ModeString; esc_d = 1'b0;
          end
          "#": mode_d = ModeHash;
          "/": mode_d = ModePendSlash;
          default: begin
            b.recs[b.cnt[1:0]] = '{RecContent, TokEof, CmtNone, c, 16'd0, ErrNone};
            b.cnt = b.cnt + 1'b1;
            if (c == "+" || c == "-" || is_dig(c)) begin
              dbl_d = 1'b0; txt_d = 1'b1; mode_d = ModeNumber;
            end else if (is_alp(c) || c == "_") begin
              kw_d = (c == "t") ? 4'd1 : (c == "f") ? 4'd5 : 4'd0;
              mode_d = ModeIdent;
            end else begin
              b.recs[b.cnt[1:0]] = '{RecFinish, TokUnknown, CmtNone, 8'd0, line_q[15:0],
                                     ErrNone};
              b.cnt = b.cnt + 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= 16'd1;
      mode_q   <= ModeIdle;
      esc_q    <= 1'b0;
      dbl_q    <= 1'b0;
      txt_q    <= 1'b0;
      kw_q     <= '0;
      line_q   <= LineBits'(1);
      cstart_q <= '0;
    end else begin
      if (cfg_valid_i) start_q <= cfg_data_i;
      if (push_o) begin
        mode_q   <= mode_d;
        esc_q    <= esc_d;
        dbl_q    <= dbl_d;
        txt_q    <= txt_d;
        kw_q     <= kw_d;
        line_q   <= line_d;
        cstart_q <= cstart_d;
      end
    end
  end

endmodule

>>> rtl/core/ctl_back.sv
`timescale 1ns / 1ps
module ctl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ctl_pkg::bundle_t bundle_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ctl_pkg::rec_t    rec_o,
  output logic             last_o
);
  import ctl_pkg::*;

  bundle_t               q_q [QDepth];
  logic [QIdxBits-1:0]   wp_q, rp_q;
  logic [QIdxBits:0]     fill_q;
  logic [CntBits-1:0]    sub_q;
  logic                  push_eff, pop;
  bundle_t               head;

  assign head     = q_q[rp_q];
  assign push_eff = push_i && (bundle_i.cnt != '0);
  assign full_o   = (fill_q == (QIdxBits+1)'(QDepth));
  assign out_valid_o = (fill_q != '0);
  assign rec_o    = head.recs[sub_q[1:0]];
  assign last_o   = (sub_q + 1'b1 == head.cnt);
  assign pop      = out_valid_o && out_ready_i && last_o;

  always_ff @(posedge clk_i) begin
    if (push_eff) q_q[wp_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
      sub_q  <= '0;
    end else begin
      if (push_eff) wp_q <= wp_q + 1'b1;
      if (out_valid_o && out_ready_i) begin
        sub_q <= last_o ? '0 : sub_q + 1'b1;
        if (last_o) rp_q <= rp_q + 1'b1;
      end
      fill_q <= fill_q + (QIdxBits+1)'(push_eff) - (QIdxBits+1)'(pop);
    end
  end

endmodule

>>> rtl/core/config_text_lexer.sv
`timescale 1ns / 1ps
// Key = value text lexer. One byte (or end-of-stream mark) is taken per cycle
// while the four-entry result queue has room; each byte yields zero to four
// records which drain one per cycle while the master side is ready, so the sustained
// rate is one byte per cycle when each byte yields at most one record, otherwise
// set by the output drain. line_start takes effect at end of stream; reset starts at line 1.
module config_text_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // byte_in
  input  logic        s_axis_tuser_i,   // end_of_stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // token_kind, comment_kind, data_byte, line_number, error_code
  output logic        m_axis_tuser_o,   // record_kind
  output logic        m_axis_tlast_o    // last_of_run
);
  import ctl_pkg::*;

  logic    push, full;
  bundle_t bundle;
  rec_t    rec;

  ctl_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .byte_i(s_axis_tdata_i), .eos_i(s_axis_tuser_i),
    .push_o(push), .full_i(full), .bundle_o(bundle)
  );

  ctl_back u_back (
    .clk_i, .rst_ni, .push_i(push), .bundle_i(bundle), .full_o(full),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .rec_o(rec), .last_o(m_axis_tlast_o)
  );

  assign m_axis_tuser_o = rec.kind;
  assign m_axis_tdata_o = {7'd0, rec.err, rec.line, rec.data, rec.cmt, rec.tok};

  a_eos_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && rec.kind == RecFinish && rec.tok == TokEof |-> m_axis_tlast_o)
    else $error("eof record not last");
  a_content_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && rec.kind == RecContent |-> rec.err == ErrNone)
    else $error("content with error");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !s_axis_tready_o)
    else $error("accept while full");

endmodule
